// File: hdl/dmuds_pkg.sv
package dmuds_pkg;

   // field widths fixed by the item format
   localparam int CMD_W       = 2;
   localparam int LETTER_W    = 5;
   localparam int VALUE_W     = 16;
   localparam int SCORE_OUT_W = 31;
   localparam int POS_W       = 16;

   // defaults of the top-level parameters
   localparam int ALPHABET_SIZE_DEF = 32;
   localparam int MAX_DIAG_LEN_DEF  = 65536;
   localparam int SCORE_BITS_DEF    = 16;

   // queue between the lookup front and the scoring back
   localparam int QDEPTH   = 4;
   localparam int QPTR_W   = $clog2(QDEPTH);
   localparam int QLEVEL_W = $clog2(QDEPTH + 1);

   // saturation ceiling of the running sum
   localparam logic [SCORE_OUT_W-1:0] SUM_MAX = {SCORE_OUT_W{1'b1}};

   typedef enum logic [CMD_W-1:0] {
      CMD_WR_STRUCT = 2'd0,
      CMD_WR_AMINO  = 2'd1,
      CMD_SCORE     = 2'd2
   } cmd_type;

   // queue status seen by the front
   typedef struct packed {
      logic [QLEVEL_W-1:0] level;
   } queue_stat_type;

endpackage

// File: hdl/dmuds_ifs.sv
interface dmuds_req_if;
   import dmuds_pkg::*;

   logic                valid;
   logic                ready;
   logic [CMD_W-1:0]    command;
   logic [LETTER_W-1:0] query_struct_letter;
   logic [LETTER_W-1:0] query_amino_letter;
   logic [LETTER_W-1:0] target_struct_letter;
   logic [LETTER_W-1:0] target_amino_letter;
   logic [LETTER_W-1:0] table_row;
   logic [LETTER_W-1:0] table_col;
   logic signed [VALUE_W-1:0] table_value;
   logic                last_column;

   modport source (
      output valid, command, query_struct_letter, query_amino_letter,
             target_struct_letter, target_amino_letter, table_row, table_col,
             table_value, last_column,
      input  ready
   );

   modport sink (
      input  valid, command, query_struct_letter, query_amino_letter,
             target_struct_letter, target_amino_letter, table_row, table_col,
             table_value, last_column,
      output ready
   );
endinterface

interface dmuds_rsp_if;
   import dmuds_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [SCORE_OUT_W-1:0] best_score;
   logic [POS_W-1:0]       best_start;
   logic [POS_W-1:0]       best_end;

   modport source (
      output valid, best_score, best_start, best_end,
      input  ready
   );

   modport sink (
      input  valid, best_score, best_start, best_end,
      output ready
   );
endinterface

// File: hdl/dual_matrix_ungapped_diagonal_score.sv
// Channel    | Dir | Handshake   | Payload
// req_bus    | in  | valid/ready | command, letters, table entry, last_column
// rsp_bus    | out | valid/ready | best_score, best_start, best_end
//
// One item per cycle while the queue has room. A scored column is read from
// both tables at its accept edge, enters the 4-entry queue on the next edge and
// is summed at the queue head; a last column's result is then registered.
// Table writes take effect at their accept edge and produce nothing.
// Reset clears the running diagonal state and the queue; tables stay undefined.
// A stalled result holds the last column in the queue; the front keeps taking
// items until the queue is full.
module dual_matrix_ungapped_diagonal_score #(
   parameter int ALPHABET_SIZE = dmuds_pkg::ALPHABET_SIZE_DEF,
   parameter int MAX_DIAG_LEN  = dmuds_pkg::MAX_DIAG_LEN_DEF,
   parameter int SCORE_BITS    = dmuds_pkg::SCORE_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   dmuds_req_if.sink   req_bus,
   dmuds_rsp_if.source rsp_bus
);
   import dmuds_pkg::*;

   localparam int ENTRY_W = 2 * SCORE_BITS + 1;

   logic               push, pop, pop_valid;
   logic [ENTRY_W-1:0] push_data, pop_data;
   queue_stat_type     q_stat;

   // look up both tables and classify items
   dmuds_front #(
      .ALPHABET_SIZE (ALPHABET_SIZE),
      .SCORE_BITS    (SCORE_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_bus),
      .q_stat    (q_stat),
      .push      (push),
      .push_data (push_data)
   );

   // decouple lookups from scoring
   dmuds_fifo #(.WIDTH(ENTRY_W)) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_valid (pop_valid),
      .pop_data  (pop_data),
      .q_stat    (q_stat)
   );

   // running sum, best segment and result
   dmuds_back #(
      .MAX_DIAG_LEN (MAX_DIAG_LEN),
      .SCORE_BITS   (SCORE_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_data  (pop_data),
      .pop       (pop),
      .rsp       (rsp_bus)
   );
endmodule

// File: hdl/dmuds_ram.sv
module dmuds_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// File: hdl/dmuds_front.sv
module dmuds_front #(
   parameter int ALPHABET_SIZE = dmuds_pkg::ALPHABET_SIZE_DEF,
   parameter int SCORE_BITS    = dmuds_pkg::SCORE_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   dmuds_req_if.sink                      req,
   input  dmuds_pkg::queue_stat_type      q_stat,
   output logic                           push,
   output logic [2*SCORE_BITS:0]          push_data
);
   import dmuds_pkg::*;

   localparam int DEPTH  = ALPHABET_SIZE * ALPHABET_SIZE;
   localparam int ADDR_W = $clog2(DEPTH);

   logic                  accept;
   logic                  row_ok, col_ok, wr_ok;
   logic                  qs_ok, ts_ok, qa_ok, ta_ok;
   logic                  wr_struct, wr_amino, rd_en;
   logic [ADDR_W-1:0]     wr_addr, rd_s_addr, rd_a_addr;
   logic [SCORE_BITS-1:0] wr_data, s_raw, a_raw, s_score, a_score;

   logic f_valid_ff, f_valid_in;
   logic f_last_ff;
   logic f_s_ok_ff;
   logic f_a_ok_ff;

   // take an item only when the queue has room for everything in flight
   assign req.ready = ({1'b0, q_stat.level} + (QLEVEL_W + 1)'(f_valid_ff))
                      < (QLEVEL_W + 1)'(QDEPTH);
   assign accept    = req.valid && req.ready;

   // range checks on letters
   assign row_ok = 32'(req.table_row) < ALPHABET_SIZE;
   assign col_ok = 32'(req.table_col) < ALPHABET_SIZE;
   assign wr_ok  = row_ok && col_ok;
   assign qs_ok  = 32'(req.query_struct_letter)  < ALPHABET_SIZE;
   assign ts_ok  = 32'(req.target_struct_letter) < ALPHABET_SIZE;
   assign qa_ok  = 32'(req.query_amino_letter)   < ALPHABET_SIZE;
   assign ta_ok  = 32'(req.target_amino_letter)  < ALPHABET_SIZE;

   // table addresses: row times alphabet size plus column
   assign wr_addr   = ADDR_W'(32'(req.table_row) * ALPHABET_SIZE + 32'(req.table_col));
   assign rd_s_addr = ADDR_W'(32'(req.query_struct_letter) * ALPHABET_SIZE
                              + 32'(req.target_struct_letter));
   assign rd_a_addr = ADDR_W'(32'(req.query_amino_letter) * ALPHABET_SIZE
                              + 32'(req.target_amino_letter));
   assign wr_data   = req.table_value[SCORE_BITS-1:0];

   // classify the item
   always_comb begin
      wr_struct = 1'b0;
      wr_amino  = 1'b0;
      rd_en     = 1'b0;
      unique case (req.command)
         CMD_WR_STRUCT: wr_struct = accept && wr_ok;
         CMD_WR_AMINO:  wr_amino  = accept && wr_ok;
         CMD_SCORE:     rd_en     = accept;
         default: ;
      endcase
   end

   dmuds_ram #(.WIDTH(SCORE_BITS), .DEPTH(DEPTH)) u_struct_ram (
      .clock   (clock),
      .wr_en   (wr_struct),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_s_addr),
      .rd_data (s_raw)
   );

   dmuds_ram #(.WIDTH(SCORE_BITS), .DEPTH(DEPTH)) u_amino_ram (
      .clock   (clock),
      .wr_en   (wr_amino),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_a_addr),
      .rd_data (a_raw)
   );

   assign f_valid_in = rd_en;

   // hold the column flags while the tables are read
   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else begin
         f_valid_ff <= f_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         f_last_ff <= req.last_column;
         f_s_ok_ff <= qs_ok && ts_ok;
         f_a_ok_ff <= qa_ok && ta_ok;
      end
   end

   // letters outside the alphabet score zero
   assign s_score   = f_s_ok_ff ? s_raw : '0;
   assign a_score   = f_a_ok_ff ? a_raw : '0;
   assign push      = f_valid_ff;
   assign push_data = {f_last_ff, s_score, a_score};
endmodule

// File: hdl/dmuds_fifo.sv
module dmuds_fifo #(
   parameter int WIDTH = 33
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  logic [WIDTH-1:0]          push_data,
   input  logic                      pop,
   output logic                      pop_valid,
   output logic [WIDTH-1:0]          pop_data,
   output dmuds_pkg::queue_stat_type q_stat
);
   import dmuds_pkg::*;

   logic [WIDTH-1:0]    entry_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QLEVEL_W-1:0] level_ff, level_in;

   // advance pointers and level
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      level_in  = level_ff;
      priority if (push && !pop) begin
         level_in = level_ff + 1'b1;
      end else if (pop && !push) begin
         level_in = level_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_valid    = level_ff != '0;
   assign pop_data     = entry_ff[rd_ptr_ff];
   assign q_stat.level = level_ff;
endmodule

// File: hdl/dmuds_back.sv
module dmuds_back #(
   parameter int MAX_DIAG_LEN = dmuds_pkg::MAX_DIAG_LEN_DEF,
   parameter int SCORE_BITS   = dmuds_pkg::SCORE_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  pop_valid,
   input  logic [2*SCORE_BITS:0] pop_data,
   output logic                  pop,
   dmuds_rsp_if.source           rsp
);
   import dmuds_pkg::*;

   localparam int CIDX_W = $clog2(MAX_DIAG_LEN);
   localparam int SUM_W  = SCORE_OUT_W + 2;

   logic                          last;
   logic signed [SCORE_BITS-1:0]  s_score, a_score;
   logic signed [SUM_W-1:0]       sum;
   logic [SCORE_OUT_W-1:0]        new_run;
   logic [31:0]                   pos_wide;
   logic [POS_W-1:0]              pos, pos_next;
   logic [CIDX_W:0]               col_inc;
   logic                          out_free;

   logic [SCORE_OUT_W-1:0] run_ff, run_in;
   logic [SCORE_OUT_W-1:0] best_ff, best_in;
   logic [POS_W-1:0]       bstart_ff, bstart_in;
   logic [POS_W-1:0]       bend_ff, bend_in;
   logic [POS_W-1:0]       cand_ff, cand_in;
   logic [CIDX_W-1:0]      col_ff, col_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [SCORE_OUT_W-1:0] rsp_score_ff;
   logic [POS_W-1:0]       rsp_start_ff;
   logic [POS_W-1:0]       rsp_end_ff;

   assign last    = pop_data[2*SCORE_BITS];
   assign s_score = pop_data[2*SCORE_BITS-1:SCORE_BITS];
   assign a_score = pop_data[SCORE_BITS-1:0];

   // a last column waits until the result register is free
   assign out_free = !rsp_valid_ff || rsp.ready;
   assign pop      = pop_valid && (!last || out_free);

   // column position, reported modulo the position width
   assign pos_wide = 32'(col_ff);
   assign pos      = pos_wide[POS_W-1:0];
   assign pos_next = pos + 1'b1;
   assign col_inc  = {1'b0, col_ff} + 1'b1;

   // add both table scores, saturate on top, clear at or below zero
   always_comb begin
      sum     = signed'({2'b00, run_ff}) + SUM_W'(s_score) + SUM_W'(a_score);
      new_run = sum[SCORE_OUT_W-1:0];
      cand_in = cand_ff;
      priority if (sum > signed'({2'b00, SUM_MAX})) begin
         new_run = SUM_MAX;
      end else if (sum <= 0) begin
         new_run = '0;
         cand_in = pos_next;
      end

      run_in    = new_run;
      best_in   = best_ff;
      bstart_in = bstart_ff;
      bend_in   = bend_ff;
      if (new_run > best_ff) begin
         best_in   = new_run;
         bstart_in = cand_ff;
         bend_in   = pos;
      end

      col_in = (col_inc >= (CIDX_W + 1)'(MAX_DIAG_LEN)) ? '0 : col_inc[CIDX_W-1:0];
   end

   // advance the diagonal state; clear it after the last column
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff    <= '0;
         best_ff   <= '0;
         bstart_ff <= '0;
         bend_ff   <= '0;
         cand_ff   <= '0;
         col_ff    <= '0;
      end else if (pop) begin
         if (last) begin
            run_ff    <= '0;
            best_ff   <= '0;
            bstart_ff <= '0;
            bend_ff   <= '0;
            cand_ff   <= '0;
            col_ff    <= '0;
         end else begin
            run_ff    <= run_in;
            best_ff   <= best_in;
            bstart_ff <= bstart_in;
            bend_ff   <= bend_in;
            cand_ff   <= cand_in;
            col_ff    <= col_in;
         end
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (pop && last) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && last) begin
         rsp_score_ff <= best_in;
         rsp_start_ff <= bstart_in;
         rsp_end_ff   <= bend_in;
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.best_score = rsp_score_ff;
   assign rsp.best_start = rsp_start_ff;
   assign rsp.best_end   = rsp_end_ff;
endmodule

// File: sim/dmuds_checker.sv
module dmuds_checker (
   input  logic clock,
   input  logic reset,
   dmuds_req_if req_bus,
   dmuds_rsp_if rsp_bus,
   output int   errors,
   output int   pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import dmuds_pkg::*;

   localparam int ALPHA    = ALPHABET_SIZE_DEF;
   localparam int DIAG_LEN = MAX_DIAG_LEN_DEF;

   typedef struct packed {
      logic [SCORE_OUT_W-1:0] score;
      logic [POS_W-1:0]       start_col;
      logic [POS_W-1:0]       end_col;
   } diag_best_type;

   // substitution tables; values are kept at full width since SCORE_BITS is 16
   logic signed [VALUE_W-1:0] struct_scores [ALPHA][ALPHA];
   logic signed [VALUE_W-1:0] amino_scores  [ALPHA][ALPHA];

   // running state of the current diagonal
   logic [SCORE_OUT_W-1:0] run_sum;
   logic [SCORE_OUT_W-1:0] peak_sum;
   logic [POS_W-1:0]       peak_start;
   logic [POS_W-1:0]       peak_end;
   logic [POS_W-1:0]       seg_start;
   int                     col_pos;

   diag_best_type diag_best_q[$];
   int            fail_count = 0;

   assign errors = fail_count;

   task automatic report_mismatch(input string msg);
      fail_count++;
      $display("%0t ns: diagonal score mismatch: %s", $time, msg);
   endtask

   task automatic clear_diagonal();
      run_sum    = '0;
      peak_sum   = '0;
      peak_start = '0;
      peak_end   = '0;
      seg_start  = '0;
      col_pos    = 0;
   endtask

   // add one column to the running sum and track the best segment
   task automatic predict_column();
      longint           sum;
      logic [POS_W-1:0] pos;
      diag_best_type    best;
      pos = col_pos[POS_W-1:0];
      sum = longint'(run_sum)
          + longint'(struct_scores[req_bus.query_struct_letter][req_bus.target_struct_letter])
          + longint'(amino_scores[req_bus.query_amino_letter][req_bus.target_amino_letter]);
      if (sum > longint'(SUM_MAX))
         sum = longint'(SUM_MAX);
      // a sum at or below zero restarts the segment at the next column
      if (sum <= 0) begin
         sum       = 0;
         seg_start = pos + 16'd1;
      end
      run_sum = sum[SCORE_OUT_W-1:0];
      if (run_sum > peak_sum) begin
         peak_sum   = run_sum;
         peak_start = seg_start;
         peak_end   = pos;
      end
      col_pos = (col_pos + 1 >= DIAG_LEN) ? 0 : col_pos + 1;
      if (req_bus.last_column) begin
         best.score     = peak_sum;
         best.start_col = peak_start;
         best.end_col   = peak_end;
         diag_best_q.push_back(best);
         clear_diagonal();
      end
   endtask

   task automatic take_item();
      case (cmd_type'(req_bus.command))
         CMD_WR_STRUCT: begin
            struct_scores[req_bus.table_row][req_bus.table_col] = req_bus.table_value;
         end
         CMD_WR_AMINO: begin
            amino_scores[req_bus.table_row][req_bus.table_col] = req_bus.table_value;
         end
         CMD_SCORE: begin
            predict_column();
         end
         default: begin
         end
      endcase
   endtask

   // compare one delivered result with the oldest prediction
   task automatic check_result();
      diag_best_type want;
      if (diag_best_q.size() == 0) begin
         report_mismatch($sformatf("unexpected result score %0d start %0d end %0d",
                                   rsp_bus.best_score, rsp_bus.best_start, rsp_bus.best_end));
         return;
      end
      want = diag_best_q.pop_front();
      if (rsp_bus.best_score !== want.score)
         report_mismatch($sformatf("best_score got %0d want %0d",
                                   rsp_bus.best_score, want.score));
      if (rsp_bus.best_start !== want.start_col)
         report_mismatch($sformatf("best_start got %0d want %0d",
                                   rsp_bus.best_start, want.start_col));
      if (rsp_bus.best_end !== want.end_col)
         report_mismatch($sformatf("best_end got %0d want %0d",
                                   rsp_bus.best_end, want.end_col));
   endtask

   // watch both channels at every edge
   always @(posedge clock) begin
      if (reset) begin
         clear_diagonal();
         diag_best_q.delete();
      end else begin
         if (rsp_bus.valid && rsp_bus.ready)
            check_result();
         if (req_bus.valid && req_bus.ready)
            take_item();
      end
      pending <= diag_best_q.size();
   end

endmodule

// File: sim/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import dmuds_pkg::*;

   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int MAX_GAP      = 18;
   localparam int STALL_LIMIT  = 2000;
   localparam int RANDOM_ITEMS = 1050;
   localparam int DRAIN_CYCLES = 20;
   localparam logic signed [VALUE_W-1:0] VALUE_MAX = 16'sh7fff;
   localparam logic signed [VALUE_W-1:0] VALUE_MIN = 16'sh8000;
   localparam logic [LETTER_W-1:0] LT_LO = 5'd0;
   localparam logic [LETTER_W-1:0] LT_HI = 5'd31;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   errors;
   int   pending;
   int   quiet_cycles = 0;
   bit   send_burst   = 1'b0;
   bit   take_burst   = 1'b0;
   bit   send_no_idle = 1'b0;
   int   random_items = 0;

   // table entries written so far; columns only look up written entries
   bit                      st_written [32][32];
   bit                      am_written [32][32];
   logic [2*LETTER_W-1:0]   st_keys[$];
   logic [2*LETTER_W-1:0]   am_keys[$];

   dmuds_req_if req_bus();
   dmuds_rsp_if rsp_bus();

   dual_matrix_ungapped_diagonal_score uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   dmuds_checker diag_check (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .errors  (errors),
      .pending (pending)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // present one item after a random gap and hold it until accepted
   task automatic send_item(input logic [CMD_W-1:0] cmd,
                            input logic [LETTER_W-1:0] qs, qa, ts, ta, row, col,
                            input logic signed [VALUE_W-1:0] value,
                            input logic is_last);
      int gap;
      if (!send_no_idle && $urandom_range(0, 39) == 0)
         send_burst = !send_burst;
      gap = (send_no_idle || send_burst) ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid                <= 1'b1;
      req_bus.command              <= cmd;
      req_bus.query_struct_letter  <= qs;
      req_bus.query_amino_letter   <= qa;
      req_bus.target_struct_letter <= ts;
      req_bus.target_amino_letter  <= ta;
      req_bus.table_row            <= row;
      req_bus.table_col            <= col;
      req_bus.table_value          <= value;
      req_bus.last_column          <= is_last;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task automatic write_entry(input cmd_type which, input logic [LETTER_W-1:0] row, col,
                              input logic signed [VALUE_W-1:0] value, input logic is_last);
      if (which == CMD_WR_STRUCT) begin
         if (!st_written[row][col]) begin
            st_written[row][col] = 1'b1;
            st_keys.push_back({row, col});
         end
      end else if (!am_written[row][col]) begin
         am_written[row][col] = 1'b1;
         am_keys.push_back({row, col});
      end
      send_item(which, LETTER_W'($urandom), LETTER_W'($urandom), LETTER_W'($urandom),
                LETTER_W'($urandom), row, col, value, is_last);
   endtask

   task automatic score_column(input logic [LETTER_W-1:0] qs, ts, qa, ta,
                               input logic is_last);
      send_item(CMD_SCORE, qs, qa, ts, ta, LETTER_W'($urandom), LETTER_W'($urandom),
                VALUE_W'($urandom), is_last);
   endtask

   // pick letters from entries already loaded in both tables
   task automatic random_column(input logic is_last);
      logic [2*LETTER_W-1:0] sk;
      logic [2*LETTER_W-1:0] ak;
      sk = st_keys[$urandom_range(0, st_keys.size() - 1)];
      ak = am_keys[$urandom_range(0, am_keys.size() - 1)];
      score_column(sk[9:5], sk[4:0], ak[9:5], ak[4:0], is_last);
   endtask

   function automatic logic signed [VALUE_W-1:0] draw_value();
      int v;
      case ($urandom_range(0, 7))
         0: v = int'(VALUE_MAX);
         1: v = int'(VALUE_MIN);
         2: v = $urandom;
         default: v = int'($urandom_range(0, 40)) - 16;
      endcase
      return v[VALUE_W-1:0];
   endfunction

   task automatic random_write();
      cmd_type which;
      which = ($urandom_range(0, 1) == 0) ? CMD_WR_STRUCT : CMD_WR_AMINO;
      write_entry(which, LETTER_W'($urandom), LETTER_W'($urandom), draw_value(),
                  1'($urandom_range(0, 1)));
      random_items++;
   endtask

   task automatic send_noise();
      send_item(CMD_UNUSED, LETTER_W'($urandom), LETTER_W'($urandom), LETTER_W'($urandom),
                LETTER_W'($urandom), LETTER_W'($urandom), LETTER_W'($urandom),
                VALUE_W'($urandom), 1'($urandom_range(0, 1)));
   endtask

   // hold the sender until every expected result has been delivered
   task automatic wait_for_drain();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   // drive every input to a known value from time zero
   initial begin
      req_bus.valid                <= 1'b0;
      req_bus.command              <= CMD_SCORE;
      req_bus.query_struct_letter  <= '0;
      req_bus.query_amino_letter   <= '0;
      req_bus.target_struct_letter <= '0;
      req_bus.target_amino_letter  <= '0;
      req_bus.table_row            <= '0;
      req_bus.table_col            <= '0;
      req_bus.table_value          <= '0;
      req_bus.last_column          <= 1'b0;
      rsp_bus.ready                <= 1'b0;
   end

   // result side: random stall before each item, with bursts of none
   initial begin
      int gap;
      while (reset) @(posedge clock);
      forever begin
         if ($urandom_range(0, 39) == 0)
            take_burst = !take_burst;
         gap = take_burst ? 0 : $urandom_range(0, MAX_GAP);
         if (gap > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
      end
   end

   // end the run when neither channel moves for too long
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int len;
      bit drained;
      drained = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // load extremes; a write ignores last_column
      write_entry(CMD_WR_STRUCT, LT_LO, LT_LO, 16'sd0, 1'b1);
      write_entry(CMD_WR_AMINO, LT_LO, LT_LO, 16'sd0, 1'b0);
      write_entry(CMD_WR_STRUCT, LT_HI, LT_HI, VALUE_MAX, 1'b0);
      write_entry(CMD_WR_AMINO, LT_HI, LT_HI, VALUE_MAX, 1'b1);
      write_entry(CMD_WR_STRUCT, LT_LO, LT_HI, VALUE_MIN, 1'b0);
      write_entry(CMD_WR_AMINO, LT_HI, LT_LO, VALUE_MIN, 1'b0);

      // nothing positive gives an all-zero result
      score_column(LT_LO, LT_LO, LT_LO, LT_LO, 1'b1);
      // unused command gives nothing
      send_noise();
      // clear at start, peak, small dip, then drop below zero on the last column
      score_column(LT_LO, LT_HI, LT_HI, LT_LO, 1'b0);
      score_column(LT_HI, LT_HI, LT_HI, LT_HI, 1'b0);
      score_column(LT_LO, LT_HI, LT_HI, LT_HI, 1'b0);
      score_column(LT_LO, LT_HI, LT_HI, LT_LO, 1'b1);
      // single-column diagonal
      score_column(LT_HI, LT_HI, LT_HI, LT_HI, 1'b1);
      // overwrite an entry and see the new value used
      write_entry(CMD_WR_STRUCT, LT_HI, LT_HI, 16'sd1, 1'b0);
      score_column(LT_HI, LT_HI, LT_LO, LT_LO, 1'b1);
      write_entry(CMD_WR_STRUCT, LT_HI, LT_HI, VALUE_MAX, 1'b0);
      wait_for_drain();

      // back-to-back stretch of maximal columns, closed by a dropping last column
      send_no_idle = 1'b1;
      repeat (40) score_column(LT_HI, LT_HI, LT_HI, LT_HI, 1'b0);
      score_column(LT_LO, LT_HI, LT_HI, LT_LO, 1'b1);
      send_no_idle = 1'b0;

      // random part: mostly diagonals, some table updates and noise
      while (random_items < RANDOM_ITEMS) begin
         if (!drained && random_items >= RANDOM_ITEMS / 2) begin
            wait_for_drain();
            drained = 1'b1;
         end
         case ($urandom_range(0, 19))
            0, 1, 2: begin
               repeat ($urandom_range(1, 4)) random_write();
            end
            3: begin
               send_noise();
            end
            default: begin
               len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 80)
                                                 : $urandom_range(1, 12);
               for (int i = 0; i < len; i++) begin
                  // break up the diagonal now and then
                  if ($urandom_range(0, 9) == 0) begin
                     if ($urandom_range(0, 1) == 0)
                        random_write();
                     else
                        send_noise();
                  end
                  random_column(i == len - 1);
                  random_items++;
               end
            end
         endcase
      end

      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
